// ===== src/sbfd_pkg.sv =====
package sbfd_pkg;

	localparam int FRAME_BYTES   = 25;
	localparam int POS_W         = $clog2(FRAME_BYTES + 1);
	// bytes 1..14 carry the ten packed channels
	localparam int PAYLOAD_BYTES = 14;
	localparam int FLAG_INDEX    = 23;
	localparam int CH_W          = 11;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] HEAD_BYTE    = 8'h0F;
	localparam logic [7:0] END_BYTE     = 8'h00;
	localparam logic [7:0] OFFLINE_FLAG = 8'h0C;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 11;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TWO_POS_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THREE_POS_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THREE_POS_HI  = 3'd4;

	localparam logic [10:0] CENTER_OFFSET_RST = 11'd1024;
	localparam logic [9:0]  DEAD_ZONE_RST     = 10'd120;
	localparam logic [10:0] TWO_POS_THR_RST   = 11'd1024;
	localparam logic [10:0] THREE_POS_LOW_RST = 11'd600;
	localparam logic [10:0] THREE_POS_HI_RST  = 11'd1400;

	localparam int OUT_W = 80;

	typedef struct packed {
		logic [10:0] center_offset;
		logic [9:0]  dead_zone;
		logic [10:0] two_pos_threshold;
		logic [10:0] three_pos_low;
		logic [10:0] three_pos_high;
	} cfg_t;

	typedef struct packed {
		logic [PAYLOAD_BYTES-1:0][7:0] data;
		logic                          online;
	} frame_t;

endpackage

// ===== src/sbfd_front.sv =====
module sbfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] rx_byte
	input  logic [0:0]      s_tuser,   // [0] frame_start
	input  logic            q_full,
	output logic            push,
	output sbfd_pkg::frame_t frame
);

	logic [sbfd_pkg::POS_W-1:0] pos_q;
	logic [sbfd_pkg::POS_W-1:0] wpos;
	logic                       take;
	logic                       accept;
	logic                       head_ok_q;
	logic                       offline_q;
	logic [sbfd_pkg::PAYLOAD_BYTES-1:0][7:0] data_q;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// bytes with no open frame, or past the end of one, are dropped
	always_comb begin
		take = s_tuser[0] || (pos_q != '0 &&
			pos_q < sbfd_pkg::POS_W'(sbfd_pkg::FRAME_BYTES));
		wpos = s_tuser[0] ? '0 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && take) begin
			pos_q <= wpos + sbfd_pkg::POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take && wpos == '0) begin
			head_ok_q <= (s_tdata == sbfd_pkg::HEAD_BYTE);
		end
		if (accept && take && wpos == sbfd_pkg::POS_W'(sbfd_pkg::FLAG_INDEX)) begin
			offline_q <= (s_tdata == sbfd_pkg::OFFLINE_FLAG);
		end
	end

	for (genvar i = 0; i < sbfd_pkg::PAYLOAD_BYTES; i++) begin : g_byte
		always_ff @(posedge clk) begin
			if (accept && take && wpos == sbfd_pkg::POS_W'(i + 1)) begin
				data_q[i] <= s_tdata;
			end
		end
	end

	assign push = accept && take &&
		wpos == sbfd_pkg::POS_W'(sbfd_pkg::FRAME_BYTES - 1) &&
		head_ok_q && s_tdata == sbfd_pkg::END_BYTE;

	assign frame.data   = data_q;
	assign frame.online = !offline_q;

endmodule

// ===== src/sbfd_queue.sv =====
module sbfd_queue #(
	parameter int DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sbfd_pkg::frame_t push_data,
	output logic             full,
	input  logic             pop,
	output sbfd_pkg::frame_t pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbfd_pkg::frame_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/sbfd_back.sv =====
module sbfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sbfd_pkg::cfg_t   cfg,
	input  logic             q_empty,
	input  sbfd_pkg::frame_t frame,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	// [0] link_online, [11:1] left_horizontal, [22:12] left_vertical,
	// [33:23] right_horizontal, [44:34] right_vertical, [45] switch_a,
	// [47:46] switch_b, [49:48] switch_c, [50] switch_d, [61:51] aux_a,
	// [72:62] aux_b, [79:73] zero
	output logic [sbfd_pkg::OUT_W-1:0] m_tdata
);

	localparam logic [1:0] SW_LOW  = 2'd0;
	localparam logic [1:0] SW_MID  = 2'd1;
	localparam logic [1:0] SW_HIGH = 2'd2;

	function automatic logic [10:0] stick(input logic [10:0] ch,
			input logic [10:0] off, input logic [9:0] dz, input logic band);
		logic signed [11:0] v;
		logic signed [11:0] dzs;
		logic [10:0]        r;
		v   = $signed({1'b0, ch}) - $signed({1'b0, off});
		dzs = $signed({2'b00, dz});
		if (band && v > -dzs && v < dzs) begin
			r = '0;
		end else if (v > 12'sd1023) begin
			r = 11'h3FF;
		end else if (v < -12'sd1024) begin
			r = 11'h400;
		end else begin
			r = v[10:0];
		end
		return r;
	endfunction

	function automatic logic [1:0] three_pos(input logic [10:0] ch,
			input logic [10:0] lo, input logic [10:0] hi);
		logic [1:0] r;
		if (ch < lo) begin
			r = SW_LOW;
		end else if (ch <= hi) begin
			r = SW_MID;
		end else begin
			r = SW_HIGH;
		end
		return r;
	endfunction

	logic [sbfd_pkg::PAYLOAD_BYTES*8-1:0] flat;
	logic [9:0][10:0]                     ch;
	logic [sbfd_pkg::OUT_W-1:0]           result;
	logic                                 valid_q;
	logic [sbfd_pkg::OUT_W-1:0]           data_q;

	assign flat = frame.data;

	// channels are packed LSB first, back to back, from byte 1 on
	for (genvar i = 0; i < 10; i++) begin : g_ch
		assign ch[i] = flat[i*sbfd_pkg::CH_W +: sbfd_pkg::CH_W];
	end

	always_comb begin
		result        = '0;
		result[0]     = frame.online;
		result[11:1]  = stick(ch[3], cfg.center_offset, cfg.dead_zone, 1'b1);
		result[22:12] = stick(ch[2], cfg.center_offset, cfg.dead_zone, 1'b0);
		result[33:23] = stick(ch[0], cfg.center_offset, cfg.dead_zone, 1'b1);
		result[44:34] = stick(ch[1], cfg.center_offset, cfg.dead_zone, 1'b1);
		result[45]    = (ch[4] >= cfg.two_pos_threshold);
		result[47:46] = three_pos(ch[5], cfg.three_pos_low, cfg.three_pos_high);
		result[49:48] = three_pos(ch[6], cfg.three_pos_low, cfg.three_pos_high);
		result[50]    = (ch[7] >= cfg.two_pos_threshold);
		result[61:51] = ch[8];
		result[72:62] = ch[9];
	end

	assign pop = !q_empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// ===== src/sbus_frame_decoder.sv =====
// Path: the edge that accepts the last (25th) byte of a good frame writes the
// frame queue; the output register loads the frame when it is popped, which
// waits behind earlier frames and while m_tdata holds a result not yet taken.
// Throughput: one byte per cycle; s_tready drops only while the frame queue
// is full. One result per good frame.
// Reset: byte position, queue and output valid clear; registers take defaults.
module sbus_frame_decoder #(
	parameter int QUEUE_DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
	input  logic [0:0]                     s_tuser,  // [0] frame_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] link_online, [11:1] left_horizontal, [22:12] left_vertical,
	// [33:23] right_horizontal, [44:34] right_vertical, [45] switch_a,
	// [47:46] switch_b, [49:48] switch_c, [50] switch_d, [61:51] aux_a,
	// [72:62] aux_b, [79:73] zero
	output logic [sbfd_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [sbfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbfd_pkg::CFG_W-1:0]     cfg_data
);

	sbfd_pkg::cfg_t   cfg_q;
	sbfd_pkg::frame_t push_frame;
	sbfd_pkg::frame_t pop_frame;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_offset     <= sbfd_pkg::CENTER_OFFSET_RST;
			cfg_q.dead_zone         <= sbfd_pkg::DEAD_ZONE_RST;
			cfg_q.two_pos_threshold <= sbfd_pkg::TWO_POS_THR_RST;
			cfg_q.three_pos_low     <= sbfd_pkg::THREE_POS_LOW_RST;
			cfg_q.three_pos_high    <= sbfd_pkg::THREE_POS_HI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbfd_pkg::REG_CENTER_OFFSET: cfg_q.center_offset <= cfg_data;
				sbfd_pkg::REG_DEAD_ZONE:     cfg_q.dead_zone <= cfg_data[9:0];
				sbfd_pkg::REG_TWO_POS_THR:   cfg_q.two_pos_threshold <= cfg_data;
				sbfd_pkg::REG_THREE_POS_LOW: cfg_q.three_pos_low <= cfg_data;
				sbfd_pkg::REG_THREE_POS_HI:  cfg_q.three_pos_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sbfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (q_push),
		.frame    (push_frame)
	);

	sbfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_frame),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_frame),
		.empty     (q_empty)
	);

	sbfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.frame    (pop_frame),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("frame pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("frame popped from empty queue");

	a_pop_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_tvalid) else $error("popped frame gave no result");

	a_drain_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !q_pop) |=> !m_tvalid)
		else $error("result repeated after it was taken");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	// index past the last register: the write must be ignored
	localparam logic [sbfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int PHASE_BYTES = 310;

	typedef struct packed {
		logic [10:0] aux_b;
		logic [10:0] aux_a;
		logic        switch_d;
		logic [1:0]  switch_c;
		logic [1:0]  switch_b;
		logic        switch_a;
		logic [10:0] right_vertical;
		logic [10:0] right_horizontal;
		logic [10:0] left_vertical;
		logic [10:0] left_horizontal;
		logic        link_online;
	} sbus_result_t;

	typedef enum int {
		FR_GOOD, FR_BAD_HEAD, FR_BAD_END, FR_SHORT, FR_LONG, FR_STRAY
	} frame_kind_t;

	class frame_scoreboard;
		logic [7:0]   store [sbfd_pkg::FRAME_BYTES];
		int           pos;
		logic [10:0]  center_offset     = sbfd_pkg::CENTER_OFFSET_RST;
		logic [9:0]   dead_zone         = sbfd_pkg::DEAD_ZONE_RST;
		logic [10:0]  two_pos_threshold = sbfd_pkg::TWO_POS_THR_RST;
		logic [10:0]  three_pos_low     = sbfd_pkg::THREE_POS_LOW_RST;
		logic [10:0]  three_pos_high    = sbfd_pkg::THREE_POS_HI_RST;
		sbus_result_t expected_frames [$];
		int           errors;
		int           checked;
		int           good_frames;
		int           bad_frames;
		int           dropped_bytes;

		function void set_reg(logic [sbfd_pkg::CFG_IDX_W-1:0] idx,
				logic [sbfd_pkg::CFG_W-1:0] val);
			case (idx)
			sbfd_pkg::REG_CENTER_OFFSET: center_offset = val;
			sbfd_pkg::REG_DEAD_ZONE:     dead_zone = val[9:0];
			sbfd_pkg::REG_TWO_POS_THR:   two_pos_threshold = val;
			sbfd_pkg::REG_THREE_POS_LOW: three_pos_low = val;
			sbfd_pkg::REG_THREE_POS_HI:  three_pos_high = val;
			default: ;
			endcase
		endfunction

		function logic [10:0] centre_stick(logic [10:0] ch, bit deadband);
			int v;
			v = int'(ch) - int'(center_offset);
			if (deadband && v > -int'(dead_zone) && v < int'(dead_zone))
				v = 0;
			if (v > 1023)
				v = 1023;
			if (v < -1024)
				v = -1024;
			return 11'(v);
		endfunction

		function logic [1:0] three_pos(logic [10:0] ch);
			if (ch < three_pos_low)
				return 2'd0;
			if (ch <= three_pos_high)
				return 2'd1;
			return 2'd2;
		endfunction

		function sbus_result_t decode_frame();
			logic [8*sbfd_pkg::PAYLOAD_BYTES-1:0] payload;
			logic [10:0]                          ch [10];
			sbus_result_t                         r;
			for (int k = 1; k <= sbfd_pkg::PAYLOAD_BYTES; k++)
				payload[8*(k-1) +: 8] = store[k];
			for (int i = 0; i < 10; i++)
				ch[i] = payload[11*i +: 11];
			r.link_online      = (store[sbfd_pkg::FLAG_INDEX] != sbfd_pkg::OFFLINE_FLAG);
			r.left_horizontal  = centre_stick(ch[3], 1'b1);
			r.left_vertical    = centre_stick(ch[2], 1'b0);
			r.right_horizontal = centre_stick(ch[0], 1'b1);
			r.right_vertical   = centre_stick(ch[1], 1'b1);
			r.switch_a         = (ch[4] >= two_pos_threshold);
			r.switch_b         = three_pos(ch[5]);
			r.switch_c         = three_pos(ch[6]);
			r.switch_d         = (ch[7] >= two_pos_threshold);
			r.aux_a            = ch[8];
			r.aux_b            = ch[9];
			return r;
		endfunction

		// returns 1 when the byte lands in the frame store
		function bit note_byte(logic [7:0] b, bit start);
			if (start) begin
				pos = 0;
			end else if (pos == 0 || pos >= sbfd_pkg::FRAME_BYTES) begin
				dropped_bytes++;
				return 1'b0;
			end
			store[pos] = b;
			pos++;
			if (pos < sbfd_pkg::FRAME_BYTES)
				return 1'b1;
			if (store[0] != sbfd_pkg::HEAD_BYTE ||
					store[sbfd_pkg::FRAME_BYTES-1] != sbfd_pkg::END_BYTE) begin
				bad_frames++;
				return 1'b1;
			end
			good_frames++;
			expected_frames.push_back(decode_frame());
			return 1'b1;
		endfunction

		function string fmt(sbus_result_t r);
			return $sformatf({"online=%0d lh=%0d lv=%0d rh=%0d rv=%0d",
				" sw=%0d/%0d/%0d/%0d aux=%0d/%0d"},
				r.link_online, $signed(r.left_horizontal), $signed(r.left_vertical),
				$signed(r.right_horizontal), $signed(r.right_vertical), r.switch_a,
				r.switch_b, r.switch_c, r.switch_d, r.aux_a, r.aux_b);
		endfunction

		function void check_result(logic [sbfd_pkg::OUT_W-1:0] data);
			sbus_result_t act;
			sbus_result_t exp;
			string        diff;
			act = data[$bits(sbus_result_t)-1:0];
			checked++;
			if (expected_frames.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result %0d with no frame pending: %s", checked, fmt(act));
				return;
			end
			exp = expected_frames.pop_front();
			diff = "";
			if (act.link_online !== exp.link_online)           diff = {diff, " link_online"};
			if (act.left_horizontal !== exp.left_horizontal)   diff = {diff, " left_horizontal"};
			if (act.left_vertical !== exp.left_vertical)       diff = {diff, " left_vertical"};
			if (act.right_horizontal !== exp.right_horizontal) diff = {diff, " right_horizontal"};
			if (act.right_vertical !== exp.right_vertical)     diff = {diff, " right_vertical"};
			if (act.switch_a !== exp.switch_a)                 diff = {diff, " switch_a"};
			if (act.switch_b !== exp.switch_b)                 diff = {diff, " switch_b"};
			if (act.switch_c !== exp.switch_c)                 diff = {diff, " switch_c"};
			if (act.switch_d !== exp.switch_d)                 diff = {diff, " switch_d"};
			if (act.aux_a !== exp.aux_a)                       diff = {diff, " aux_a"};
			if (act.aux_b !== exp.aux_b)                       diff = {diff, " aux_b"};
			if (diff != "") begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result %0d differs in%s", checked, diff);
					$display("  expected %s", fmt(exp));
					$display("  actual   %s", fmt(act));
				end
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;
	logic [0:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [sbfd_pkg::OUT_W-1:0]     m_tdata;
	logic                           cfg_we    = 1'b0;
	logic [sbfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sbfd_pkg::CFG_W-1:0]     cfg_data  = '0;

	frame_scoreboard sb = new();

	logic [7:0]  frame_bytes [sbfd_pkg::FRAME_BYTES];
	logic [10:0] cur_center = sbfd_pkg::CENTER_OFFSET_RST;
	logic [9:0]  cur_dead   = sbfd_pkg::DEAD_ZONE_RST;
	logic [10:0] cur_two    = sbfd_pkg::TWO_POS_THR_RST;
	logic [10:0] cur_low    = sbfd_pkg::THREE_POS_LOW_RST;
	logic [10:0] cur_high   = sbfd_pkg::THREE_POS_HI_RST;
	int          burst_left;
	int          bytes_stored;
	int          requests;
	int          settings = 1;
	int          rx_mode;
	int          rx_stall;
	int          rx_timer;

	sbus_frame_decoder dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$display("timeout: %0d results still pending", sb.pending());
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				requests++;
				bytes_stored += sb.note_byte(s_tdata, s_tuser[0]);
			end
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// receiver: switches at random between open, choppy and long-stall modes
	always @(posedge clk) begin
		rx_timer++;
		if (rx_timer % 300 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= ($urandom_range(0, 3) != 0);
		default: begin
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				rx_stall = $urandom_range(5, 40);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
		endcase
	end

	function automatic logic [10:0] pick_channel();
		logic [10:0] nudge;
		nudge = 11'($urandom_range(0, 2)) - 11'd1;
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return 11'($urandom_range(0, 2047));
		4: return 11'h000;
		5: return 11'h7FF;
		6: return cur_center + 11'(cur_dead) + nudge;
		7: return cur_center - 11'(cur_dead) + nudge;
		8: return cur_two + nudge;
		default: return (($urandom_range(0, 1) != 0) ? cur_low : cur_high) + nudge;
		endcase
	endfunction

	function automatic void build_frame();
		logic [8*sbfd_pkg::PAYLOAD_BYTES-1:0] payload;
		for (int k = 0; k < sbfd_pkg::PAYLOAD_BYTES; k++)
			payload[8*k +: 8] = 8'($urandom);
		for (int i = 0; i < 10; i++)
			payload[11*i +: 11] = pick_channel();
		frame_bytes[0] = sbfd_pkg::HEAD_BYTE;
		for (int k = 1; k <= sbfd_pkg::PAYLOAD_BYTES; k++)
			frame_bytes[k] = payload[8*(k-1) +: 8];
		for (int k = sbfd_pkg::PAYLOAD_BYTES + 1; k < sbfd_pkg::FRAME_BYTES - 1; k++)
			frame_bytes[k] = 8'($urandom);
		if ($urandom_range(0, 4) == 0)
			frame_bytes[sbfd_pkg::FLAG_INDEX] = sbfd_pkg::OFFLINE_FLAG;
		frame_bytes[sbfd_pkg::FRAME_BYTES-1] = sbfd_pkg::END_BYTE;
	endfunction

	// one request per call; bursts of random length, occasionally a long clean one
	task automatic send_byte(logic [7:0] b, bit start);
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic send_frame(int n);
		for (int k = 0; k < n; k++)
			send_byte(frame_bytes[k], k == 0);
	endtask

	// sample at negedge so the monitor has seen the last accepted request
	task automatic wait_decoder_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [sbfd_pkg::CFG_IDX_W-1:0] idx,
			logic [sbfd_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic [10:0] centre, logic [9:0] dz, logic [10:0] two,
			logic [10:0] lo, logic [10:0] hi);
		write_reg(sbfd_pkg::REG_CENTER_OFFSET, centre);
		write_reg(sbfd_pkg::REG_DEAD_ZONE, 11'(dz));
		write_reg(sbfd_pkg::REG_TWO_POS_THR, two);
		write_reg(sbfd_pkg::REG_THREE_POS_LOW, lo);
		write_reg(sbfd_pkg::REG_THREE_POS_HI, hi);
		cfg_we <= 1'b0;
		cur_center = centre;
		cur_dead   = dz;
		cur_two    = two;
		cur_low    = lo;
		cur_high   = hi;
		settings++;
	endtask

	task automatic run_random(int target);
		int          base;
		int          roll;
		frame_kind_t kind;
		base = bytes_stored;
		while (bytes_stored - base < target) begin
			roll = $urandom_range(0, 99);
			kind = (roll < 66) ? FR_GOOD : (roll < 74) ? FR_BAD_HEAD :
				(roll < 82) ? FR_BAD_END : (roll < 90) ? FR_SHORT :
				(roll < 96) ? FR_LONG : FR_STRAY;
			build_frame();
			case (kind)
			FR_GOOD: send_frame(sbfd_pkg::FRAME_BYTES);
			FR_BAD_HEAD: begin
				frame_bytes[0] = sbfd_pkg::HEAD_BYTE ^ 8'($urandom_range(1, 255));
				send_frame(sbfd_pkg::FRAME_BYTES);
			end
			FR_BAD_END: begin
				frame_bytes[sbfd_pkg::FRAME_BYTES-1] = 8'($urandom_range(1, 255));
				send_frame(sbfd_pkg::FRAME_BYTES);
			end
			// cut short by the next frame start
			FR_SHORT: send_frame($urandom_range(1, sbfd_pkg::FRAME_BYTES - 1));
			FR_LONG: begin
				send_frame(sbfd_pkg::FRAME_BYTES);
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
			end
			default: repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
			endcase
			if ($urandom_range(0, 29) == 0)
				wait_decoder_idle();
		end
	endtask

	initial begin
		logic [8*sbfd_pkg::PAYLOAD_BYTES-1:0] extreme_payload;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte with no frame open, then a frame abandoned by a new start
		send_byte(8'hA5, 1'b0);
		send_byte(sbfd_pkg::HEAD_BYTE, 1'b1);
		send_byte(8'h5A, 1'b0);
		// channels alternate 0 / full scale, link flagged offline, one byte too many
		for (int i = 0; i < 10; i++)
			extreme_payload[11*i +: 11] = (i % 2 != 0) ? 11'h7FF : 11'h000;
		extreme_payload[8*sbfd_pkg::PAYLOAD_BYTES-1 -: 2] = 2'b11;
		frame_bytes[0] = sbfd_pkg::HEAD_BYTE;
		for (int k = 1; k <= sbfd_pkg::PAYLOAD_BYTES; k++)
			frame_bytes[k] = extreme_payload[8*(k-1) +: 8];
		for (int k = sbfd_pkg::PAYLOAD_BYTES + 1; k < sbfd_pkg::FRAME_BYTES; k++)
			frame_bytes[k] = 8'hFF;
		frame_bytes[sbfd_pkg::FLAG_INDEX] = sbfd_pkg::OFFLINE_FLAG;
		frame_bytes[sbfd_pkg::FRAME_BYTES-1] = sbfd_pkg::END_BYTE;
		send_frame(sbfd_pkg::FRAME_BYTES);
		send_byte(8'hFF, 1'b0);

		run_random(PHASE_BYTES);
		wait_decoder_idle();

		for (int phase = 1; phase <= 5; phase++) begin
			case (phase)
			1: begin
				write_reg(REG_UNUSED, '1);
				set_config('0, '0, '0, '0, '0);
			end
			2: set_config('1, '1, '1, '1, '1);
			// crossed three-position thresholds
			3: set_config(11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)),
				11'($urandom_range(0, 2047)), 11'($urandom_range(1024, 2047)),
				11'($urandom_range(0, 1023)));
			4: set_config(11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)),
				11'($urandom_range(0, 2047)), 11'($urandom_range(0, 1023)),
				11'($urandom_range(1024, 2047)));
			default: set_config(sbfd_pkg::CENTER_OFFSET_RST, sbfd_pkg::DEAD_ZONE_RST,
				sbfd_pkg::TWO_POS_THR_RST, sbfd_pkg::THREE_POS_LOW_RST,
				sbfd_pkg::THREE_POS_HI_RST);
			endcase
			run_random(PHASE_BYTES);
			wait_decoder_idle();
		end
		repeat (10) @(posedge clk);

		$display("Run: %0d requests over %0d register settings, %0d bytes ignored",
			requests, settings, sb.dropped_bytes);
		$display("Frames: %0d decoded and checked, %0d rejected on head/end, %0d mismatches",
			sb.good_frames, sb.bad_frames, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
